// File: rtl/datetime_difference_seconds_assert.svh
// ----------------------------------------------------------------------------
// datetime difference assertion macros
// shared concurrent check forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef DATETIME_DIFFERENCE_SECONDS_ASSERT_SVH
`define DATETIME_DIFFERENCE_SECONDS_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define DTD_CHECK(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define DTD_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// types, calendar constants and helper functions for the datetime difference
// ----------------------------------------------------------------------------
`default_nettype none

package dtd_pkg;

    // pipeline depth per unit
    localparam int CONV_STG  = 2;
    localparam int DIFF_STG  = 5;
    localparam int SPLIT_STG = 4;
    localparam int STAGES    = CONV_STG + DIFF_STG + SPLIT_STG;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    // reciprocals: x / 25 = (x * 5243) >> 17 for x < 8192
    localparam logic [12:0] RECIP_25   = 13'd5243;
    // x / 3600 = (x * 37283) >> 27 for x < 86400
    localparam logic [15:0] RECIP_HOUR = 16'd37283;
    // x / 60 = (x * 4370) >> 18 for x < 3600
    localparam logic [12:0] RECIP_MIN  = 13'd4370;

    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date;

    // one date converted: whole-year days, day offset in year, second of day
    typedef struct packed {
        logic        ok;
        logic [22:0] ydays;
        logic [10:0] moff;
        logic [16:0] sod;
    } t_conv;

    // absolute difference split into days and remainder
    typedef struct packed {
        logic        ok;
        logic        later;
        logic [39:0] total;
        logic [23:0] days;
        logic [16:0] rem;
    } t_span;

    typedef struct packed {
        logic        ok;
        logic        later;
        logic [39:0] total;
        logic [23:0] days;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_res;

    function automatic logic [7:0] div25(input logic [12:0] m);
        logic [25:0] p;
        p = 26'(m) * 26'(RECIP_25);
        return p[24:17];
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] n;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  n = 5'd30;
            4'd2:                                     n = 5'd28;
            default:                                  n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/datetime_difference_seconds.sv
// ----------------------------------------------------------------------------
// datetime_difference_seconds
// absolute difference of two proleptic gregorian date-times, in seconds and
// as days/hours/minutes/seconds, with a validity flag for both inputs
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every clock while o_stall is
// low. Each result passes through 2 conversion stages per date in parallel,
// 5 difference/normalize stages and 4 split stages; the last stage is the
// output register. All divisions are by constants and done as shifts and
// reciprocal multiplies. Each stage holds a valid bit, so bubbles collapse
// while the output is stalled and o_stall rises only when every stage holds
// a transaction and i_stall is high.
`default_nettype none

`include "datetime_difference_seconds_assert.svh"

module datetime_difference_seconds import dtd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_first_day,
    input  logic [3:0]  i_first_month,
    input  logic [13:0] i_first_year,
    input  logic [4:0]  i_first_hour,
    input  logic [5:0]  i_first_minute,
    input  logic [5:0]  i_first_second,
    input  logic [5:0]  i_second_day,
    input  logic [3:0]  i_second_month,
    input  logic [13:0] i_second_year,
    input  logic [4:0]  i_second_hour,
    input  logic [5:0]  i_second_minute,
    input  logic [5:0]  i_second_second,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_both_valid,
    output logic        o_first_later,
    output logic [39:0] o_total_seconds,
    output logic [23:0] o_whole_days,
    output logic [4:0]  o_rest_hours,
    output logic [5:0]  o_rest_minutes,
    output logic [5:0]  o_rest_seconds
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] vld_in;
    logic [STAGES-1:0] rdy;

    t_date first_date;
    t_date second_date;
    t_conv conv_a;
    t_conv conv_b;
    t_span span;
    t_res  res;

    // a stage may load when it or any stage after it is empty, or output is free
    always_comb begin
        vld_in = {r_vld[STAGES-2:0], i_valid};
        for (int k = 0; k < STAGES; k++) begin
            rdy[k]   = !i_stall || ((r_vld | STAGES'((1 << k) - 1)) != '1);
            n_vld[k] = rdy[k] ? vld_in[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign first_date = '{day: i_first_day, month: i_first_month, year: i_first_year,
                          hour: i_first_hour, minute: i_first_minute,
                          second: i_first_second};
    assign second_date = '{day: i_second_day, month: i_second_month, year: i_second_year,
                           hour: i_second_hour, minute: i_second_minute,
                           second: i_second_second};

    dtd_conv u_conv_a (
        .i_clk  (i_clk),
        .i_en   (rdy[CONV_STG-1:0]),
        .i_date (first_date),
        .o_conv (conv_a)
    );

    dtd_conv u_conv_b (
        .i_clk  (i_clk),
        .i_en   (rdy[CONV_STG-1:0]),
        .i_date (second_date),
        .o_conv (conv_b)
    );

    dtd_diff u_diff (
        .i_clk  (i_clk),
        .i_en   (rdy[CONV_STG+DIFF_STG-1:CONV_STG]),
        .i_a    (conv_a),
        .i_b    (conv_b),
        .o_span (span)
    );

    dtd_split u_split (
        .i_clk  (i_clk),
        .i_en   (rdy[STAGES-1:CONV_STG+DIFF_STG]),
        .i_span (span),
        .o_res  (res)
    );

    assign o_stall         = !rdy[0];
    assign o_valid         = r_vld[STAGES-1];
    assign o_both_valid    = res.ok;
    assign o_first_later   = res.later;
    assign o_total_seconds = res.total;
    assign o_whole_days    = res.days;
    assign o_rest_hours    = res.hours;
    assign o_rest_minutes  = res.minutes;
    assign o_rest_seconds  = res.seconds;

    `DTD_CHECK(a_rest_range, i_clk, i_rst_n, !o_valid || (o_rest_hours <= 5'd23 && o_rest_minutes <= 6'd59 && o_rest_seconds <= 6'd59), "remainder field out of range")
    `DTD_CHECK(a_split_sum, i_clk, i_rst_n, !o_valid || (o_total_seconds == 40'(o_whole_days) * 40'd86400 + 40'(o_rest_hours) * 40'd3600 + 40'(o_rest_minutes) * 40'd60 + 40'(o_rest_seconds)), "split does not add up to total")
    `DTD_CHECK(a_later_nonzero, i_clk, i_rst_n, !(o_valid && o_first_later) || (o_total_seconds != 40'd0), "first_later with zero difference")
    `DTD_CHECK(a_no_stall_free, i_clk, i_rst_n, i_stall || !o_stall, "input stalled while output is free")
    `DTD_CHECK_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0], "accepted transaction missing from first stage")

endmodule

`default_nettype wire

// File: rtl/dtd_conv.sv
// ----------------------------------------------------------------------------
// dtd_conv
// two-stage conversion of one date-time into day and second-of-day counts
// ----------------------------------------------------------------------------
`default_nettype none

module dtd_conv import dtd_pkg::*; (
    input  logic                i_clk,
    input  logic [CONV_STG-1:0] i_en,
    input  t_date               i_date,
    output t_conv               o_conv
);

    // stage 1: year quotients, second of day, range checks
    logic [14:0] n_y3;
    logic [14:0] n_y99;
    logic [14:0] n_y399;
    logic [16:0] n_sod;
    logic        n_range_ok;

    logic [13:0] r_y;
    logic [3:0]  r_month;
    logic [5:0]  r_day;
    logic [16:0] r_sod;
    logic [12:0] r_yq4;
    logic [7:0]  r_c100;
    logic [7:0]  r_c400;
    logic [7:0]  r_f100;
    logic [7:0]  r_f400;
    logic        r_range_ok;

    always_comb begin
        n_y3   = {1'b0, i_date.year} + 15'd3;
        n_y99  = {1'b0, i_date.year} + 15'd99;
        n_y399 = {1'b0, i_date.year} + 15'd399;
        n_sod  = 17'(i_date.hour) * 17'(SEC_PER_HOUR) + 17'(i_date.minute) * 17'(SEC_PER_MIN)
               + 17'(i_date.second);
        n_range_ok = (i_date.month >= MONTH_JAN) && (i_date.month <= MONTH_DEC)
                  && (i_date.year <= YEAR_MAX) && (i_date.hour <= HOUR_MAX)
                  && (i_date.minute <= MIN_MAX) && (i_date.second <= MIN_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_y        <= i_date.year;
            r_month    <= i_date.month;
            r_day      <= i_date.day;
            r_sod      <= n_sod;
            r_yq4      <= n_y3[14:2];
            r_c100     <= div25(n_y99[14:2]);
            r_c400     <= div25({2'b0, n_y399[14:4]});
            r_f100     <= div25({1'b0, i_date.year[13:2]});
            r_f400     <= div25({3'b0, i_date.year[13:4]});
            r_range_ok <= n_range_ok;
        end
    end

    // stage 2: leap test, days before the year, offset within the year
    logic [11:0] n_f100x25;
    logic [9:0]  n_f400x25;
    logic        n_leap;
    logic [12:0] n_leaps;
    logic [22:0] n_ydays;
    logic        n_mo_ok;
    logic [9:0]  n_u;
    logic [10:0] n_moff;
    logic [4:0]  n_limit;
    logic        n_ok;

    t_conv r_conv;

    always_comb begin
        n_f100x25 = 12'(r_f100) * 12'd25;
        n_f400x25 = 10'(r_f400) * 10'd25;
        n_leap = ((r_y[1:0] == 2'd0) && (r_y[13:2] != n_f100x25))
              || ((r_y[3:0] == 4'd0) && (r_y[13:4] == n_f400x25));
        n_leaps = r_yq4 + 13'(r_c400) - 13'(r_c100);
        n_ydays = 23'(r_y) * 23'(DAYS_PER_YEAR) + 23'(n_leaps);
        n_mo_ok = (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC);
        // leap day also applies to out-of-range months above february
        n_u = (n_mo_ok ? (10'(days_before(r_month)) + 10'(r_day)) : 10'd0)
            + {9'b0, (n_leap && (r_month > MONTH_FEB))};
        n_moff = {1'b0, n_u} - {10'b0, n_mo_ok};
        n_limit = ((r_month == MONTH_FEB) && n_leap) ? FEB_LEAP_LEN : month_len(r_month);
        n_ok = r_range_ok && (r_day != 6'd0) && (r_day <= {1'b0, n_limit});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_conv.ok    <= n_ok;
            r_conv.ydays <= n_ydays;
            r_conv.moff  <= n_moff;
            r_conv.sod   <= r_sod;
        end
    end

    assign o_conv = r_conv;

endmodule

`default_nettype wire

// File: rtl/dtd_diff.sv
// ----------------------------------------------------------------------------
// dtd_diff
// signed difference of two instants, absolute value, day/second normalization
// ----------------------------------------------------------------------------
`default_nettype none

module dtd_diff import dtd_pkg::*; (
    input  logic                i_clk,
    input  logic [DIFF_STG-1:0] i_en,
    input  t_conv               i_a,
    input  t_conv               i_b,
    output t_span               o_span
);

    localparam logic signed [17:0] DAY_S  = 18'sd86400;
    localparam logic signed [18:0] DAY_W  = 19'sd86400;
    localparam logic signed [18:0] DAY2_W = 19'sd172800;

    // stage 3: day and second-of-day differences
    logic signed [11:0] n_dm;
    logic signed [24:0] n_dd;
    logic signed [17:0] n_ds;
    logic signed [24:0] r3_dd;
    logic signed [17:0] r3_ds;
    logic               r3_ok;

    always_comb begin
        n_dm = $signed({i_a.moff[10], i_a.moff}) - $signed({i_b.moff[10], i_b.moff});
        n_dd = $signed({2'b0, i_a.ydays}) - $signed({2'b0, i_b.ydays}) + 25'(n_dm);
        n_ds = $signed({1'b0, i_a.sod}) - $signed({1'b0, i_b.sod});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r3_dd <= n_dd;
            r3_ds <= n_ds;
            r3_ok <= i_a.ok & i_b.ok;
        end
    end

    // stage 4: days scaled to seconds
    logic signed [41:0] n_prod;
    logic signed [41:0] r4_prod;
    logic signed [24:0] r4_dd;
    logic signed [17:0] r4_ds;
    logic               r4_ok;

    assign n_prod = r3_dd * DAY_S;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r4_prod <= n_prod;
            r4_dd   <= r3_dd;
            r4_ds   <= r3_ds;
            r4_ok   <= r3_ok;
        end
    end

    // stage 5: full signed difference
    logic signed [41:0] r5_t;
    logic signed [24:0] r5_dd;
    logic signed [17:0] r5_ds;
    logic               r5_ok;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r5_t  <= r4_prod + 42'(r4_ds);
            r5_dd <= r4_dd;
            r5_ds <= r4_ds;
            r5_ok <= r4_ok;
        end
    end

    // stage 6: direction and absolute value
    logic               n_later;
    logic signed [41:0] n_neg_t;
    logic [39:0]        r6_total;
    logic signed [24:0] r6_nd;
    logic signed [17:0] r6_nds;
    logic               r6_later;
    logic               r6_ok;

    always_comb begin
        n_later = !r5_t[41] && (r5_t != 42'sd0);
        n_neg_t = -r5_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r6_total <= r5_t[41] ? n_neg_t[39:0] : r5_t[39:0];
            r6_nd    <= n_later ? r5_dd : -r5_dd;
            r6_nds   <= n_later ? r5_ds : -r5_ds;
            r6_later <= n_later;
            r6_ok    <= r5_ok;
        end
    end

    // stage 7: pull second of day into 0..86399, carrying into the day count
    logic signed [18:0] n_s19;
    logic signed [18:0] n_rem;
    logic signed [24:0] n_days;
    t_span              r7_span;

    always_comb begin
        n_s19 = 19'(r6_nds);
        if (r6_nds < -DAY_S) begin
            n_rem  = n_s19 + DAY2_W;
            n_days = r6_nd - 25'sd2;
        end else if (r6_nds < 18'sd0) begin
            n_rem  = n_s19 + DAY_W;
            n_days = r6_nd - 25'sd1;
        end else if (r6_nds >= DAY_S) begin
            n_rem  = n_s19 - DAY_W;
            n_days = r6_nd + 25'sd1;
        end else begin
            n_rem  = n_s19;
            n_days = r6_nd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r7_span.ok    <= r6_ok;
            r7_span.later <= r6_later;
            r7_span.total <= r6_total;
            r7_span.days  <= n_days[23:0];
            r7_span.rem   <= n_rem[16:0];
        end
    end

    assign o_span = r7_span;

endmodule

`default_nettype wire

// File: rtl/dtd_split.sv
// ----------------------------------------------------------------------------
// dtd_split
// splits the second-of-day remainder into hours, minutes and seconds
// ----------------------------------------------------------------------------
`default_nettype none

module dtd_split import dtd_pkg::*; (
    input  logic                 i_clk,
    input  logic [SPLIT_STG-1:0] i_en,
    input  t_span                i_span,
    output t_res                 o_res
);

    typedef struct packed {
        logic        ok;
        logic        later;
        logic [39:0] total;
        logic [23:0] days;
    } t_head;

    // stage 8: hours by reciprocal multiply
    logic [32:0] n_hp;
    t_head       r8_head;
    logic [16:0] r8_rem;
    logic [4:0]  r8_hrs;

    assign n_hp = 33'(i_span.rem) * 33'(RECIP_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r8_head <= '{ok: i_span.ok, later: i_span.later,
                         total: i_span.total, days: i_span.days};
            r8_rem  <= i_span.rem;
            r8_hrs  <= n_hp[31:27];
        end
    end

    // stage 9: seconds left in the hour
    logic [16:0] n_rem_h;
    t_head       r9_head;
    logic [4:0]  r9_hrs;
    logic [11:0] r9_rem;

    assign n_rem_h = r8_rem - 17'(r8_hrs) * 17'(SEC_PER_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r9_head <= r8_head;
            r9_hrs  <= r8_hrs;
            r9_rem  <= n_rem_h[11:0];
        end
    end

    // stage 10: minutes by reciprocal multiply
    logic [24:0] n_mp;
    t_head       r10_head;
    logic [4:0]  r10_hrs;
    logic [11:0] r10_rem;
    logic [5:0]  r10_min;

    assign n_mp = 25'(r9_rem) * 25'(RECIP_MIN);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r10_head <= r9_head;
            r10_hrs  <= r9_hrs;
            r10_rem  <= r9_rem;
            r10_min  <= n_mp[23:18];
        end
    end

    // stage 11: seconds, output register
    logic [11:0] n_sec;
    t_res        r11_res;

    assign n_sec = r10_rem - 12'(r10_min) * 12'(SEC_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r11_res.ok      <= r10_head.ok;
            r11_res.later   <= r10_head.later;
            r11_res.total   <= r10_head.total;
            r11_res.days    <= r10_head.days;
            r11_res.hours   <= r10_hrs;
            r11_res.minutes <= r10_min;
            r11_res.seconds <= n_sec[5:0];
        end
    end

    assign o_res = r11_res;

endmodule

`default_nettype wire

// File: dv/tb_datetime_difference_seconds.sv
// ----------------------------------------------------------------------------
// tb_datetime_difference_seconds
// Checks the date-time difference pipeline against its own calendar model.
// A table of directed date pairs runs first, then several hundred random
// pairs, mostly real calendar dates with some raw bit noise. Idle cycles on
// the input side and stalls on the result side vary over three phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_datetime_difference_seconds import dtd_pkg::*;;

    localparam int      RANDOM_PER_PHASE = 150;
    localparam int      DRAIN_CYCLES     = 30;
    localparam int      CYCLE_LIMIT      = 200000;
    localparam longint  DAY_SECS         = 86400;
    localparam longint  HOUR_SECS        = 3600;
    localparam longint  MIN_SECS         = 60;
    localparam int      CUM_DAYS[13]   = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int      MONTH_DAYS[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        t_date first_dt;
        t_date second_dt;
        bit    typed;
        t_res  want;
    } t_stim_row;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_date first_in = '0;
    t_date second_in = '0;
    logic  o_stall;
    logic  o_valid;
    logic  o_both_valid;
    logic  o_first_later;
    logic  [39:0] o_total_seconds;
    logic  [23:0] o_whole_days;
    logic  [4:0]  o_rest_hours;
    logic  [5:0]  o_rest_minutes;
    logic  [5:0]  o_rest_seconds;

    t_res      expected_spans[$];
    t_stim_row dir_rows[$];
    int        sender_idle_pct = 10;
    int        receiver_stall_pct = 62;
    int        mismatch_count = 0;
    int        pairs_sent = 0;
    int        spans_checked = 0;
    int        valid_spans = 0;

    datetime_difference_seconds u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_first_day     (first_in.day),
        .i_first_month   (first_in.month),
        .i_first_year    (first_in.year),
        .i_first_hour    (first_in.hour),
        .i_first_minute  (first_in.minute),
        .i_first_second  (first_in.second),
        .i_second_day    (second_in.day),
        .i_second_month  (second_in.month),
        .i_second_year   (second_in.year),
        .i_second_hour   (second_in.hour),
        .i_second_minute (second_in.minute),
        .i_second_second (second_in.second),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_both_valid    (o_both_valid),
        .o_first_later   (o_first_later),
        .o_total_seconds (o_total_seconds),
        .o_whole_days    (o_whole_days),
        .o_rest_hours    (o_rest_hours),
        .o_rest_minutes  (o_rest_minutes),
        .o_rest_seconds  (o_rest_seconds)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------ calendar

    function automatic bit is_leap(longint yr);
        return (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
    endfunction

    function automatic int days_in_month(logic [3:0] month, logic [13:0] year);
        if (month < MONTH_JAN || month > MONTH_DEC) return 0;
        if (month == MONTH_FEB && is_leap(longint'(year))) return int'(FEB_LEAP_LEN);
        return MONTH_DAYS[month];
    endfunction

    // seconds since 1 jan of year 0; day zero may push it below zero
    function automatic longint instant_seconds(t_date d);
        longint yr;
        longint days;
        yr = longint'(d.year);
        days = yr * 365 + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
        if (d.month >= MONTH_JAN && d.month <= MONTH_DEC)
            days += CUM_DAYS[d.month] + longint'(d.day) - 1;
        // out-of-range months above february still pick up the leap day
        if (d.month > MONTH_FEB && is_leap(yr))
            days += 1;
        return days * DAY_SECS + longint'(d.hour) * HOUR_SECS
               + longint'(d.minute) * MIN_SECS + longint'(d.second);
    endfunction

    function automatic bit date_is_valid(t_date d);
        if (d.month < MONTH_JAN || d.month > MONTH_DEC) return 1'b0;
        if (d.year > YEAR_MAX || d.hour > HOUR_MAX || d.minute > MIN_MAX || d.second > MIN_MAX)
            return 1'b0;
        return d.day >= 1 && int'(d.day) <= days_in_month(d.month, d.year);
    endfunction

    function automatic t_res span_between(t_date first_dt, t_date second_dt);
        t_res   r;
        longint a;
        longint b;
        longint diff;
        longint rem;
        a = instant_seconds(first_dt);
        b = instant_seconds(second_dt);
        diff = (a > b) ? a - b : b - a;
        rem = diff % DAY_SECS;
        r.ok      = date_is_valid(first_dt) && date_is_valid(second_dt);
        r.later   = a > b;
        r.total   = diff[39:0];
        r.days    = 24'(diff / DAY_SECS);
        r.hours   = 5'(rem / HOUR_SECS);
        r.minutes = 6'((rem % HOUR_SECS) / MIN_SECS);
        r.seconds = 6'(rem % MIN_SECS);
        return r;
    endfunction

    // ------------------------------------------------------------------ stimulus

    function automatic t_date mk_date(int day, int month, int year, int hour, int minute,
                                      int sec);
        t_date d;
        d.day    = 6'(day);
        d.month  = 4'(month);
        d.year   = 14'(year);
        d.hour   = 5'(hour);
        d.minute = 6'(minute);
        d.second = 6'(sec);
        return d;
    endfunction

    function automatic t_date calendar_date();
        t_date d;
        case ($urandom_range(9))
            0:       d.year = 14'($urandom_range(3));
            1:       d.year = 14'($urandom_range(9999, 9996));
            2:       d.year = 14'($urandom_range(99) * 100);
            default: d.year = 14'($urandom_range(9999));
        endcase
        d.month  = 4'($urandom_range(12, 1));
        d.day    = 6'($urandom_range(days_in_month(d.month, d.year), 1));
        d.hour   = 5'($urandom_range(23));
        d.minute = 6'($urandom_range(59));
        d.second = 6'($urandom_range(59));
        return d;
    endfunction

    function automatic t_date noise_date();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_date)-1:0];
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pair(t_date first_dt, t_date second_dt, bit typed, t_res want);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        first_in  <= first_dt;
        second_in <= second_dt;
        i_valid   <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_spans.push_back(typed ? want : span_between(first_dt, second_dt));
        pairs_sent++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // ------------------------------------------------------------------ checking

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s on difference %0d: got %0h, want %0h",
                 what, spans_checked, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_both_valid, o_first_later, o_total_seconds, o_whole_days,
                   o_rest_hours, o_rest_minutes, o_rest_seconds};
            if (expected_spans.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(got.total), 64'd0);
            end else begin
                want = expected_spans.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("both_valid", 64'(got.ok), 64'(want.ok));
                if (got.later !== want.later)
                    report_mismatch("first_later", 64'(got.later), 64'(want.later));
                if (got.total !== want.total)
                    report_mismatch("total_seconds", 64'(got.total), 64'(want.total));
                if (got.days !== want.days)
                    report_mismatch("whole_days", 64'(got.days), 64'(want.days));
                if (got.hours !== want.hours)
                    report_mismatch("rest_hours", 64'(got.hours), 64'(want.hours));
                if (got.minutes !== want.minutes)
                    report_mismatch("rest_minutes", 64'(got.minutes), 64'(want.minutes));
                if (got.seconds !== want.seconds)
                    report_mismatch("rest_seconds", 64'(got.seconds), 64'(want.seconds));
                if (want.ok) valid_spans++;
            end
            spans_checked++;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout waiting for results");
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------ main

    initial begin
        t_date a;
        t_date b;
        t_date tmp;
        int    kind;

        // typed rows: ok, later, total, days, hours, minutes, seconds
        dir_rows.push_back(t_stim_row'{mk_date(1, 1, 2000, 0, 0, 0), mk_date(1, 1, 2000, 0, 0, 0),
            1'b1, t_res'{1'b1, 1'b0, 40'd0, 24'd0, 5'd0, 6'd0, 6'd0}});
        dir_rows.push_back(t_stim_row'{mk_date(1, 1, 0, 0, 0, 1), mk_date(1, 1, 0, 0, 0, 0),
            1'b1, t_res'{1'b1, 1'b1, 40'd1, 24'd0, 5'd0, 6'd0, 6'd1}});
        dir_rows.push_back(t_stim_row'{mk_date(28, 2, 2001, 0, 0, 0), mk_date(1, 3, 2001, 0, 0, 0),
            1'b1, t_res'{1'b1, 1'b0, 40'd86400, 24'd1, 5'd0, 6'd0, 6'd0}});
        // day zero of year 0 sits one day before the epoch
        dir_rows.push_back(t_stim_row'{mk_date(0, 1, 0, 0, 0, 0), mk_date(1, 1, 0, 0, 0, 0),
            1'b1, t_res'{1'b0, 1'b0, 40'd86400, 24'd1, 5'd0, 6'd0, 6'd0}});
        dir_rows.push_back(t_stim_row'{mk_date(15, 6, 2024, 12, 0, 0),
            mk_date(15, 6, 2024, 13, 1, 1),
            1'b1, t_res'{1'b1, 1'b0, 40'd3661, 24'd0, 5'd1, 6'd1, 6'd1}});
        // month zero ignores the day
        dir_rows.push_back(t_stim_row'{mk_date(17, 0, 2000, 0, 0, 0), mk_date(1, 1, 2000, 0, 0, 0),
            1'b1, t_res'{1'b0, 1'b0, 40'd0, 24'd0, 5'd0, 6'd0, 6'd0}});
        // month 13 in a leap year still gains the leap day
        dir_rows.push_back(t_stim_row'{mk_date(9, 13, 2000, 0, 0, 0), mk_date(1, 1, 2000, 0, 0, 0),
            1'b1, t_res'{1'b0, 1'b1, 40'd86400, 24'd1, 5'd0, 6'd0, 6'd0}});
        dir_rows.push_back(t_stim_row'{mk_date(63, 15, 16383, 31, 63, 63), mk_date(0, 0, 0, 0, 0, 0),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(0, 0, 0, 0, 0, 0), mk_date(63, 15, 16383, 31, 63, 63),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(31, 12, 9999, 23, 59, 59), mk_date(1, 1, 0, 0, 0, 0),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(29, 2, 2000, 6, 30, 0), mk_date(1, 3, 2000, 0, 0, 0),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(29, 2, 1900, 0, 0, 0), mk_date(1, 3, 1900, 0, 0, 0),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(29, 2, 2001, 0, 0, 0), mk_date(1, 3, 2001, 0, 0, 0),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(29, 2, 400, 1, 2, 3), mk_date(29, 2, 100, 4, 5, 6),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(1, 1, 10000, 0, 0, 0), mk_date(31, 12, 9999, 0, 0, 0),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(10, 5, 1999, 24, 0, 0), mk_date(10, 5, 1999, 0, 60, 0),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(10, 5, 1999, 0, 0, 60), mk_date(31, 4, 1999, 0, 0, 0),
            1'b0, '0});
        dir_rows.push_back(t_stim_row'{mk_date(0, 3, 2004, 0, 0, 0), mk_date(30, 4, 2004, 23, 59, 59),
            1'b0, '0});

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            send_pair(dir_rows[k].first_dt, dir_rows[k].second_dt, dir_rows[k].typed,
                      dir_rows[k].want);

        // hold off until the pipeline has drained
        i_valid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge i_clk);
        @(negedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct    = (phase == 0) ? 10 : (phase == 1) ? 62 : 0;
            receiver_stall_pct = (phase == 0) ? 62 : (phase == 1) ? 10 : 0;
            repeat (RANDOM_PER_PHASE) begin
                kind = $urandom_range(99);
                a = calendar_date();
                b = calendar_date();
                if (kind >= 60 && kind < 75) begin
                    // close pair on the same day or month
                    b = a;
                    b.hour   = 5'($urandom_range(23));
                    b.minute = 6'($urandom_range(59));
                    b.second = 6'($urandom_range(59));
                    if ($urandom_range(1) == 1)
                        b.day = 6'($urandom_range(days_in_month(b.month, b.year), 1));
                end else if (kind >= 75 && kind < 90) begin
                    b = noise_date();
                end else if (kind >= 90) begin
                    a = noise_date();
                    b = noise_date();
                end
                if ($urandom_range(1) == 1) begin
                    tmp = a;
                    a = b;
                    b = tmp;
                end
                send_pair(a, b, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d date pairs sent, %0d of them from the directed table",
                 pairs_sent, dir_rows.size());
        $display("%0d differences checked, %0d with both date-times valid",
                 spans_checked, valid_spans);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/dtd_pkg.sv
rtl/dtd_conv.sv
rtl/dtd_diff.sv
rtl/dtd_split.sv
rtl/datetime_difference_seconds.sv
dv/tb_datetime_difference_seconds.sv
